// ----- hw/rtl/itp_pkg.sv -----
// ============================================================================
// itp_pkg - shared types and constants of the infix-to-postfix converter
// Token classes, stack entry layout, result layout, operator precedence.
// ============================================================================
package itp_pkg;

    localparam int POS_W  = 6;
    localparam int ARG_W  = 6;
    localparam int PREC_W = 3;

    localparam int TOKQ_DEPTH = 4;
    localparam int RESQ_DEPTH = 4;

    localparam logic [ARG_W-1:0] ARG_MAX = 6'd63;

    localparam logic [3:0] KIND_STRING   = 4'd1;
    localparam logic [3:0] KIND_NUMBER   = 4'd2;
    localparam logic [3:0] KIND_VARIABLE = 4'd3;
    localparam logic [3:0] KIND_OPERATOR = 4'd4;
    localparam logic [3:0] KIND_FUNCTION = 4'd5;
    localparam logic [3:0] KIND_COMMA    = 4'd6;
    localparam logic [3:0] KIND_LEFT     = 4'd7;
    localparam logic [3:0] KIND_RIGHT    = 4'd8;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_CARET = 8'h5E;

    typedef enum logic [2:0] {
        CLS_NONE,
        CLS_OPND,
        CLS_OPER,
        CLS_FUNC,
        CLS_COMMA,
        CLS_LEFT,
        CLS_RIGHT,
        CLS_OVFL
    } t_cls;

    typedef enum logic [1:0] {
        ECLS_OP   = 2'd0,
        ECLS_FUNC = 2'd1,
        ECLS_LEFT = 2'd2
    } t_ecls;

    typedef enum logic [1:0] {
        ST_EMIT   = 2'd0,
        ST_RPAREN = 2'd1,
        ST_OVFL   = 2'd2,
        ST_DONE   = 2'd3
    } t_status;

    typedef struct packed {
        t_cls              cls;
        logic [POS_W-1:0]  pos;
        logic [PREC_W-1:0] prec;
        logic              rassoc;
        logic              last;
    } t_tok;

    typedef struct packed {
        logic [PREC_W-1:0] prec;
        t_ecls             cls;
        logic [POS_W-1:0]  pos;
    } t_went;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [ARG_W-1:0] args;
        t_status          status;
    } t_emit;

    typedef struct packed {
        t_emit ent;
        logic  last;
    } t_res;

    function automatic logic [PREC_W-1:0] prec_of(input logic [7:0] ch);
        logic [PREC_W-1:0] p;
        case (ch)
            CH_LT, CH_GT, CH_EQ:      p = 3'd1;
            CH_MINUS, CH_PLUS:        p = 3'd2;
            CH_PCT, CH_STAR, CH_SLASH: p = 3'd3;
            CH_CARET:                 p = 3'd4;
            default:                  p = 3'd0;
        endcase
        return p;
    endfunction

endpackage

// ----- hw/rtl/itp_fifo.sv -----
// ============================================================================
// itp_fifo - small synchronous queue
// Register-based FIFO, DEPTH a power of two, head shown while not empty.
// ============================================================================
module itp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr;
    logic [AW-1:0]    r_rptr;
    logic [CW-1:0]    r_cnt;
    logic             wr_ok;
    logic             rd_ok;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_ok   = i_wr && !o_full;
    assign rd_ok   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (wr_ok) begin
                r_wptr <= r_wptr + AW'(1);
            end
            if (rd_ok) begin
                r_rptr <= r_rptr + AW'(1);
            end
            r_cnt <= r_cnt + CW'(wr_ok) - CW'(rd_ok);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

// ----- hw/rtl/itp_front.sv -----
// ============================================================================
// itp_front - token intake and classification
// Numbers tokens, flags token-count overflow, decodes class and precedence.
// ============================================================================
module itp_front #(
    parameter int MAX_TOKENS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [3:0]    i_token_kind,
    input  logic [7:0]    i_op_char,
    input  logic          i_last_token,
    input  logic          i_q_full,
    output logic          o_q_wr,
    output itp_pkg::t_tok o_q_tok
);

    localparam int CW = $clog2(MAX_TOKENS + 1);
    localparam int PW = itp_pkg::POS_W;

    logic [CW-1:0] r_cnt;
    logic          accept;
    logic          ovf;

    assign accept = i_push && !i_q_full;
    assign ovf    = (r_cnt >= CW'(MAX_TOKENS));
    assign o_q_wr = accept;

    always_comb begin
        o_q_tok.pos    = PW'(r_cnt);
        o_q_tok.prec   = itp_pkg::prec_of(i_op_char);
        o_q_tok.rassoc = (i_op_char == itp_pkg::CH_CARET);
        o_q_tok.last   = i_last_token;
        case (i_token_kind)
            itp_pkg::KIND_STRING,
            itp_pkg::KIND_NUMBER,
            itp_pkg::KIND_VARIABLE: o_q_tok.cls = itp_pkg::CLS_OPND;
            itp_pkg::KIND_OPERATOR: o_q_tok.cls = itp_pkg::CLS_OPER;
            itp_pkg::KIND_FUNCTION: o_q_tok.cls = itp_pkg::CLS_FUNC;
            itp_pkg::KIND_COMMA:    o_q_tok.cls = itp_pkg::CLS_COMMA;
            itp_pkg::KIND_LEFT:     o_q_tok.cls = itp_pkg::CLS_LEFT;
            itp_pkg::KIND_RIGHT:    o_q_tok.cls = itp_pkg::CLS_RIGHT;
            default:                o_q_tok.cls = itp_pkg::CLS_NONE;
        endcase
        if (ovf) begin
            o_q_tok.cls = itp_pkg::CLS_OVFL;
        end
    end

    // counter saturates on overflow; a last token restarts numbering
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (accept) begin
            if (i_last_token) begin
                r_cnt <= '0;
            end else if (!ovf) begin
                r_cnt <= r_cnt + CW'(1);
            end
        end
    end

endmodule

// ----- hw/rtl/itp_back.sv -----
// ============================================================================
// itp_back - shunting-yard execution unit
// Work stack, function stack and argument counts in memories; a sequencer
// pops and emits entries, stalling while the result queue is full, and holds
// back one result so the expression's final beat can be tagged.
// ============================================================================
module itp_back #(
    parameter int MAX_TOKENS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  itp_pkg::t_tok i_tok,
    input  logic          i_tok_empty,
    output logic          o_tok_pop,
    output logic          o_res_push,
    output itp_pkg::t_res o_res,
    input  logic          i_res_full
);

    localparam int DW    = $clog2(MAX_TOKENS + 1);
    localparam int AW    = $clog2(MAX_TOKENS);
    localparam int MDEP  = 1 << AW;
    localparam int AGW   = itp_pkg::ARG_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_ARGWR,
        S_LOOP,
        S_FPOP,
        S_PAREN2,
        S_FIN
    } t_state;

    typedef enum logic [2:0] {
        M_FLUSH,
        M_COMMA,
        M_OP,
        M_RIGHT,
        M_PFUNC
    } t_mode;

    typedef enum logic {
        A_MARK,
        A_INC
    } t_amode;

    function automatic itp_pkg::t_emit mk_emit(
        input logic [itp_pkg::POS_W-1:0] pos,
        input logic [AGW-1:0]            args,
        input itp_pkg::t_status          status
    );
        itp_pkg::t_emit e;
        e.pos    = pos;
        e.args   = args;
        e.status = status;
        return e;
    endfunction

    t_state          r_state,  n_state;
    itp_pkg::t_tok   r_tok,    n_tok;
    logic [DW-1:0]   r_wdepth, n_wdepth;
    logic [DW-1:0]   r_fdepth, n_fdepth;
    logic            r_skip,   n_skip;
    t_mode           r_mode,   n_mode;
    t_amode          r_amode,  n_amode;
    logic [AW-1:0]   r_aaddr,  n_aaddr;
    logic            r_pend_v, n_pend_v;
    itp_pkg::t_emit  r_pend,   n_pend;

    itp_pkg::t_went  r_wmem [MDEP];
    logic [AW-1:0]   r_fmem [MDEP];
    logic [AGW-1:0]  r_amem [MDEP];
    itp_pkg::t_went  r_wtop;
    logic [AW-1:0]   r_ftop;
    logic [AGW-1:0]  r_ard;

    logic            w_we;
    itp_pkg::t_went  w_wd;
    logic [AW-1:0]   w_wa;
    logic [AW-1:0]   w_ra;
    logic            f_we;
    logic [AW-1:0]   f_wa;
    logic [AW-1:0]   f_wd;
    logic [AW-1:0]   f_ra;
    logic            a_we;
    logic [AW-1:0]   a_wa;
    logic [AGW-1:0]  a_wd;
    logic [AW-1:0]   a_ra;
    logic [DW-1:0]   wd_m1;
    logic [DW-1:0]   fd_m1;

    logic            e_v;
    itp_pkg::t_emit  e_data;
    logic            fin_push;
    itp_pkg::t_res   fin_data;
    logic            need_push;
    logic            stall;
    logic            pop_req;
    logic            have;
    t_state          tail_st;

    assign have    = (r_wdepth != '0);
    assign tail_st = r_tok.last ? S_LOOP : S_FIN;
    assign w_wa    = r_wdepth[AW-1:0];
    assign f_wa    = r_fdepth[AW-1:0];
    assign f_wd    = r_tok.pos[AW-1:0];
    assign a_ra    = (r_state == S_EXEC) ? r_ftop : r_wtop.pos[AW-1:0];
    assign wd_m1   = n_wdepth - DW'(1);
    assign fd_m1   = n_fdepth - DW'(1);
    assign w_ra    = wd_m1[AW-1:0];
    assign f_ra    = fd_m1[AW-1:0];

    always_comb begin
        n_state  = r_state;
        n_tok    = r_tok;
        n_wdepth = r_wdepth;
        n_fdepth = r_fdepth;
        n_skip   = r_skip;
        n_mode   = r_mode;
        n_amode  = r_amode;
        n_aaddr  = r_aaddr;
        n_pend_v = r_pend_v;
        n_pend   = r_pend;
        w_we     = 1'b0;
        w_wd.prec = '0;
        w_wd.cls  = itp_pkg::ECLS_OP;
        w_wd.pos  = r_tok.pos;
        f_we     = 1'b0;
        a_we     = 1'b0;
        a_wa     = r_aaddr;
        a_wd     = '0;
        e_v      = 1'b0;
        e_data   = r_pend;
        fin_push = 1'b0;
        fin_data.ent  = r_pend;
        fin_data.last = r_tok.last;
        pop_req  = 1'b0;
        o_tok_pop = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (!i_tok_empty) begin
                    o_tok_pop = 1'b1;
                    n_tok     = i_tok;
                    n_state   = S_EXEC;
                end
            end
            S_EXEC: begin
                n_mode = M_FLUSH;
                if (r_skip) begin
                    n_state = S_FIN;
                end else begin
                    case (r_tok.cls)
                        itp_pkg::CLS_OVFL: begin
                            e_v     = 1'b1;
                            e_data  = mk_emit('0, '0, itp_pkg::ST_OVFL);
                            n_skip  = 1'b1;
                            n_state = S_FIN;
                        end
                        itp_pkg::CLS_OPND: begin
                            e_v    = 1'b1;
                            e_data = mk_emit(r_tok.pos, '0, itp_pkg::ST_EMIT);
                            if (r_fdepth != '0) begin
                                n_aaddr = r_ftop;
                                n_amode = A_MARK;
                                n_state = S_ARGWR;
                            end else begin
                                n_state = tail_st;
                            end
                        end
                        itp_pkg::CLS_FUNC: begin
                            a_we      = 1'b1;
                            a_wa      = r_tok.pos[AW-1:0];
                            a_wd      = '0;
                            f_we      = 1'b1;
                            n_fdepth  = r_fdepth + DW'(1);
                            w_we      = 1'b1;
                            w_wd.cls  = itp_pkg::ECLS_FUNC;
                            n_wdepth  = r_wdepth + DW'(1);
                            if (r_fdepth != '0) begin
                                n_aaddr = r_ftop;
                                n_amode = A_MARK;
                                n_state = S_ARGWR;
                            end else begin
                                n_state = tail_st;
                            end
                        end
                        itp_pkg::CLS_COMMA: begin
                            n_mode = M_COMMA;
                            if (r_fdepth != '0) begin
                                n_aaddr = r_ftop;
                                n_amode = A_INC;
                                n_state = S_ARGWR;
                            end else begin
                                n_state = S_LOOP;
                            end
                        end
                        itp_pkg::CLS_OPER: begin
                            n_mode  = M_OP;
                            n_state = S_LOOP;
                        end
                        itp_pkg::CLS_LEFT: begin
                            w_we     = 1'b1;
                            w_wd.cls = itp_pkg::ECLS_LEFT;
                            n_wdepth = r_wdepth + DW'(1);
                            n_state  = tail_st;
                        end
                        itp_pkg::CLS_RIGHT: begin
                            n_mode  = M_RIGHT;
                            n_state = S_LOOP;
                        end
                        default: begin
                            n_state = tail_st;
                        end
                    endcase
                end
            end
            S_ARGWR: begin
                a_wa = r_aaddr;
                if (r_amode == A_MARK) begin
                    a_we = (r_ard == '0);
                    a_wd = AGW'(1);
                end else begin
                    a_we = (r_ard != itp_pkg::ARG_MAX);
                    a_wd = r_ard + AGW'(1);
                end
                if (r_mode == M_COMMA) begin
                    n_state = S_LOOP;
                end else begin
                    n_mode  = M_FLUSH;
                    n_state = tail_st;
                end
            end
            S_LOOP: begin
                case (r_mode)
                    M_FLUSH: begin
                        if (have) begin
                            pop_req = 1'b1;
                        end else begin
                            n_state = S_FIN;
                        end
                    end
                    M_COMMA: begin
                        if (have && r_wtop.cls != itp_pkg::ECLS_LEFT) begin
                            pop_req = 1'b1;
                        end else begin
                            n_mode  = M_FLUSH;
                            n_state = tail_st;
                        end
                    end
                    M_RIGHT: begin
                        if (have && r_wtop.cls != itp_pkg::ECLS_LEFT) begin
                            pop_req = 1'b1;
                        end else if (!have) begin
                            e_v     = 1'b1;
                            e_data  = mk_emit(r_tok.pos, '0, itp_pkg::ST_RPAREN);
                            n_skip  = 1'b1;
                            n_state = S_FIN;
                        end else begin
                            n_wdepth = r_wdepth - DW'(1);
                            n_state  = S_PAREN2;
                        end
                    end
                    M_OP: begin
                        if (have && r_wtop.cls == itp_pkg::ECLS_OP &&
                            (r_tok.rassoc ? (r_tok.prec < r_wtop.prec)
                                          : (r_tok.prec <= r_wtop.prec))) begin
                            pop_req = 1'b1;
                        end else begin
                            w_we      = 1'b1;
                            w_wd.prec = r_tok.prec;
                            w_wd.cls  = itp_pkg::ECLS_OP;
                            n_wdepth  = r_wdepth + DW'(1);
                            n_mode    = M_FLUSH;
                            n_state   = tail_st;
                        end
                    end
                    default: begin
                        n_state = S_FIN;
                    end
                endcase
                if (pop_req) begin
                    if (r_wtop.cls == itp_pkg::ECLS_FUNC) begin
                        n_state = S_FPOP;
                    end else begin
                        e_v      = 1'b1;
                        e_data   = mk_emit(r_wtop.pos, '0, itp_pkg::ST_EMIT);
                        n_wdepth = r_wdepth - DW'(1);
                    end
                end
            end
            S_FPOP: begin
                e_v      = 1'b1;
                e_data   = mk_emit(r_wtop.pos, r_ard, itp_pkg::ST_EMIT);
                n_wdepth = r_wdepth - DW'(1);
                if (r_mode != M_FLUSH && r_fdepth != '0) begin
                    n_fdepth = r_fdepth - DW'(1);
                end
                if (r_mode == M_PFUNC) begin
                    n_mode  = M_FLUSH;
                    n_state = tail_st;
                end else begin
                    n_state = S_LOOP;
                end
            end
            S_PAREN2: begin
                if (have && r_wtop.cls == itp_pkg::ECLS_FUNC) begin
                    n_mode  = M_PFUNC;
                    n_state = S_FPOP;
                end else begin
                    n_mode  = M_FLUSH;
                    n_state = tail_st;
                end
            end
            S_FIN: begin
                fin_push = r_pend_v || r_tok.last;
                if (!r_pend_v) begin
                    fin_data.ent = mk_emit('0, '0, itp_pkg::ST_DONE);
                end
                n_pend_v = 1'b0;
                if (r_tok.last) begin
                    n_wdepth = '0;
                    n_fdepth = '0;
                    n_skip   = 1'b0;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // one result held back; it leaves when the next arrives or when the token finishes
        if (e_v) begin
            n_pend_v = 1'b1;
            n_pend   = e_data;
        end
        need_push = (e_v && r_pend_v) || fin_push;
        stall     = need_push && i_res_full;
        if (stall) begin
            n_state   = r_state;
            n_tok     = r_tok;
            n_wdepth  = r_wdepth;
            n_fdepth  = r_fdepth;
            n_skip    = r_skip;
            n_mode    = r_mode;
            n_amode   = r_amode;
            n_aaddr   = r_aaddr;
            n_pend_v  = r_pend_v;
            n_pend    = r_pend;
            w_we      = 1'b0;
            f_we      = 1'b0;
            a_we      = 1'b0;
            o_tok_pop = 1'b0;
        end
        o_res_push = need_push && !i_res_full;
        if (fin_push) begin
            o_res = fin_data;
        end else begin
            o_res.ent  = r_pend;
            o_res.last = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wdepth <= '0;
            r_fdepth <= '0;
            r_skip   <= 1'b0;
            r_mode   <= M_FLUSH;
            r_amode  <= A_MARK;
            r_pend_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_wdepth <= n_wdepth;
            r_fdepth <= n_fdepth;
            r_skip   <= n_skip;
            r_mode   <= n_mode;
            r_amode  <= n_amode;
            r_pend_v <= n_pend_v;
        end
        r_tok   <= n_tok;
        r_aaddr <= n_aaddr;
        r_pend  <= n_pend;
    end

    // stack memories track their top entry; a push bypasses the array
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_wmem[w_wa] <= w_wd;
        end
        r_wtop <= w_we ? w_wd : r_wmem[w_ra];
    end

    always_ff @(posedge i_clk) begin
        if (f_we) begin
            r_fmem[f_wa] <= f_wd;
        end
        r_ftop <= f_we ? f_wd : r_fmem[f_ra];
    end

    always_ff @(posedge i_clk) begin
        if (a_we) begin
            r_amem[a_wa] <= a_wd;
        end
        r_ard <= r_amem[a_ra];
    end

endmodule

// ----- hw/rtl/infix_to_postfix_converter.sv -----
// ============================================================================
// infix_to_postfix_converter - shunting-yard token converter
// Classified tokens in, postfix token positions with argument counts out.
// ============================================================================
//
//  channel  handshake         ports                                   dir
//  -------  ----------------  --------------------------------------  ---
//  token    push / full       i_token_kind i_op_char i_last_token     in
//  result   empty / pop       o_out_position o_arg_count o_status     out
//                             o_last_result
//
//  Sequencer: a token is taken, decoded and finished; further steps are taken
//  for an arg-count update, each popped operator or paren, closing a pop loop
//  (operator, comma, right paren, last token) and a matched right paren, and a
//  popped function adds a loop and a pop step (the latter alone after a paren).
//  4-beat token and result queues decouple the sides; a full result queue
//  stalls the sequencer. Synchronous reset clears depths, counters, queues.
//
module infix_to_postfix_converter #(
    parameter int MAX_TOKENS = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [3:0] i_token_kind,
    input  logic [7:0] i_op_char,
    input  logic       i_last_token,
    output logic       empty,
    input  logic       pop,
    output logic [5:0] o_out_position,
    output logic [5:0] o_arg_count,
    output logic [1:0] o_status,
    output logic       o_last_result
);

    localparam int TW = $bits(itp_pkg::t_tok);
    localparam int RW = $bits(itp_pkg::t_res);

    logic          q_wr;
    itp_pkg::t_tok q_tok;
    itp_pkg::t_tok q_head;
    logic          q_empty;
    logic          q_rd;
    logic          res_push;
    itp_pkg::t_res res_in;
    itp_pkg::t_res res_out;
    logic          res_full;

    itp_front #(
        .MAX_TOKENS (MAX_TOKENS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_token_kind (i_token_kind),
        .i_op_char    (i_op_char),
        .i_last_token (i_last_token),
        .i_q_full     (full),
        .o_q_wr       (q_wr),
        .o_q_tok      (q_tok)
    );

    itp_fifo #(
        .WIDTH (TW),
        .DEPTH (itp_pkg::TOKQ_DEPTH)
    ) u_tokq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_wdata (q_tok),
        .o_full  (full),
        .i_rd    (q_rd),
        .o_rdata (q_head),
        .o_empty (q_empty)
    );

    itp_back #(
        .MAX_TOKENS (MAX_TOKENS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok       (q_head),
        .i_tok_empty (q_empty),
        .o_tok_pop   (q_rd),
        .o_res_push  (res_push),
        .o_res       (res_in),
        .i_res_full  (res_full)
    );

    itp_fifo #(
        .WIDTH (RW),
        .DEPTH (itp_pkg::RESQ_DEPTH)
    ) u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_push),
        .i_wdata (res_in),
        .o_full  (res_full),
        .i_rd    (pop),
        .o_rdata (res_out),
        .o_empty (empty)
    );

    assign o_out_position = res_out.ent.pos;
    assign o_arg_count    = res_out.ent.args;
    assign o_status       = res_out.ent.status;
    assign o_last_result  = res_out.last;

endmodule

// ----- verif/infix_to_postfix_converter_tb.sv -----
// ============================================================================
// infix_to_postfix_converter_tb - self-checking bench for the token converter
// Feeds directed and random token streams through the push/full side, keeps a
// shunting-yard predictor of the postfix positions, argument counts and
// status codes, and checks every beat popped from the result side in order.
// ============================================================================
`timescale 1ns / 1ps

module infix_to_postfix_converter_tb;

    localparam int TOKEN_LIMIT  = 64;
    localparam int RES_LIMIT    = 64;
    localparam int RANDOM_ITEMS = 440;
    localparam int CALM_TAIL    = 60;
    localparam int SETTLE       = 40;

    localparam logic [3:0] KIND_NONE  = 4'd0;
    localparam logic [3:0] KIND_SPARE = 4'd15;

    typedef struct {
        logic [3:0] kind;
        logic [7:0] ch;
        logic       last;
        bit         drain;
    } t_beat;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [3:0] i_token_kind = '0;
    logic [7:0] i_op_char = '0;
    logic       i_last_token = 1'b0;
    logic       empty;
    logic       pop = 1'b0;
    logic [5:0] o_out_position;
    logic [5:0] o_arg_count;
    logic [1:0] o_status;
    logic       o_last_result;

    infix_to_postfix_converter #(
        .MAX_TOKENS(TOKEN_LIMIT)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_token_kind   (i_token_kind),
        .i_op_char      (i_op_char),
        .i_last_token   (i_last_token),
        .empty          (empty),
        .pop            (pop),
        .o_out_position (o_out_position),
        .o_arg_count    (o_arg_count),
        .o_status       (o_status),
        .o_last_result  (o_last_result)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // stimulus and expectation stores
    // ------------------------------------------------------------------------
    t_beat         token_q[$];
    t_beat         expr_q[$];
    itp_pkg::t_res postfix_q[$];
    bit            hold_next;
    int            errors;
    int            beats_in;
    bit            tok_beat;
    int            tok_gap;
    int            res_gap;
    string         op_set = "<>=+-*/%^";

    // ------------------------------------------------------------------------
    // shunting-yard predictor state
    // ------------------------------------------------------------------------
    itp_pkg::t_went stack_mem [TOKEN_LIMIT];
    int             stack_n;
    logic [5:0]     fn_mem [TOKEN_LIMIT];
    int             fn_n;
    logic [5:0]     argc_mem [TOKEN_LIMIT];
    int             tok_cnt;
    bit             skipping;
    int             step_n;

    function automatic logic [2:0] op_rank(input logic [7:0] c);
        if (c == itp_pkg::CH_CARET) return 3'd4;
        if (c == itp_pkg::CH_STAR || c == itp_pkg::CH_SLASH || c == itp_pkg::CH_PCT)
            return 3'd3;
        if (c == itp_pkg::CH_PLUS || c == itp_pkg::CH_MINUS) return 3'd2;
        if (c == itp_pkg::CH_LT || c == itp_pkg::CH_GT || c == itp_pkg::CH_EQ) return 3'd1;
        return 3'd0;
    endfunction

    task automatic note_result(input logic [5:0] p, input logic [5:0] a,
                               input itp_pkg::t_status s);
        itp_pkg::t_res r;
        if (step_n < RES_LIMIT) begin
            r.ent.pos = p;
            r.ent.args = a;
            r.ent.status = s;
            r.last = 1'b0;
            postfix_q.push_back(r);
            step_n++;
        end
    endtask

    task automatic release_top(input bit drop_fn);
        itp_pkg::t_went e;
        logic [5:0]     a;
        e = stack_mem[stack_n-1];
        stack_n--;
        a = '0;
        if (e.cls == itp_pkg::ECLS_FUNC) begin
            a = argc_mem[e.pos];
            if (drop_fn && fn_n > 0) fn_n--;
        end
        note_result(e.pos, a, itp_pkg::ST_EMIT);
    endtask

    task automatic open_arg();
        if (fn_n > 0 && argc_mem[fn_mem[fn_n-1]] == '0) argc_mem[fn_mem[fn_n-1]] = 6'd1;
    endtask

    task automatic stack_push(input logic [5:0] p, input itp_pkg::t_ecls c,
                              input logic [2:0] pr);
        itp_pkg::t_went e;
        if (stack_n < TOKEN_LIMIT) begin
            e.prec = pr;
            e.cls = c;
            e.pos = p;
            stack_mem[stack_n] = e;
            stack_n++;
        end
    endtask

    task automatic shunt_token(input logic [3:0] kind, input logic [7:0] ch, input logic last);
        logic [5:0]    pos;
        logic [2:0]    p1;
        logic [2:0]    p2;
        bit            rassoc;
        bit            ended;
        itp_pkg::t_res r;
        step_n = 0;
        ended = 1'b0;
        if (skipping) begin
            if (!last) return;
            note_result('0, '0, itp_pkg::ST_DONE);
            ended = 1'b1;
        end else if (tok_cnt >= TOKEN_LIMIT) begin
            note_result('0, '0, itp_pkg::ST_OVFL);
            skipping = 1'b1;
            ended = 1'b1;
        end
        if (!ended) begin
            pos = 6'(tok_cnt);
            tok_cnt++;
            case (kind)
                itp_pkg::KIND_STRING, itp_pkg::KIND_NUMBER, itp_pkg::KIND_VARIABLE: begin
                    note_result(pos, '0, itp_pkg::ST_EMIT);
                    open_arg();
                end
                itp_pkg::KIND_FUNCTION: begin
                    open_arg();
                    argc_mem[pos] = '0;
                    if (fn_n < TOKEN_LIMIT) begin
                        fn_mem[fn_n] = pos;
                        fn_n++;
                    end
                    stack_push(pos, itp_pkg::ECLS_FUNC, '0);
                end
                itp_pkg::KIND_COMMA: begin
                    if (fn_n > 0 && argc_mem[fn_mem[fn_n-1]] < itp_pkg::ARG_MAX)
                        argc_mem[fn_mem[fn_n-1]] = argc_mem[fn_mem[fn_n-1]] + 6'd1;
                    while (stack_n > 0 && stack_mem[stack_n-1].cls != itp_pkg::ECLS_LEFT)
                        release_top(1'b1);
                end
                itp_pkg::KIND_OPERATOR: begin
                    p1 = op_rank(ch);
                    rassoc = (ch == itp_pkg::CH_CARET);
                    while (stack_n > 0 && stack_mem[stack_n-1].cls == itp_pkg::ECLS_OP) begin
                        p2 = stack_mem[stack_n-1].prec;
                        if ((!rassoc && p1 <= p2) || (rassoc && p1 < p2)) release_top(1'b0);
                        else break;
                    end
                    stack_push(pos, itp_pkg::ECLS_OP, p1);
                end
                itp_pkg::KIND_LEFT: begin
                    stack_push(pos, itp_pkg::ECLS_LEFT, '0);
                end
                itp_pkg::KIND_RIGHT: begin
                    while (stack_n > 0 && stack_mem[stack_n-1].cls != itp_pkg::ECLS_LEFT)
                        release_top(1'b1);
                    if (stack_n == 0) begin
                        note_result(pos, '0, itp_pkg::ST_RPAREN);
                        skipping = 1'b1;
                        ended = 1'b1;
                    end else begin
                        stack_n--;
                        if (stack_n > 0 && stack_mem[stack_n-1].cls == itp_pkg::ECLS_FUNC)
                            release_top(1'b1);
                    end
                end
                default: begin
                end
            endcase
            if (!ended && last) begin
                while (stack_n > 0) release_top(1'b0);
                if (step_n == 0) note_result('0, '0, itp_pkg::ST_DONE);
            end
        end
        if (last) begin
            if (step_n > 0) begin
                r = postfix_q.pop_back();
                r.last = 1'b1;
                postfix_q.push_back(r);
            end
            stack_n = 0;
            fn_n = 0;
            tok_cnt = 0;
            skipping = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------
    task automatic flag_mismatch(input string what);
        errors++;
        $display("mismatch at %0t ns: %s", $time, what);
    endtask

    task automatic check_result();
        itp_pkg::t_res want;
        if (postfix_q.size() == 0) begin
            flag_mismatch($sformatf("unexpected beat pos %0d args %0d status %0d last %0d",
                o_out_position, o_arg_count, o_status, o_last_result));
            return;
        end
        want = postfix_q.pop_front();
        if (o_out_position !== want.ent.pos)
            flag_mismatch($sformatf("position %0d, want %0d", o_out_position, want.ent.pos));
        if (o_arg_count !== want.ent.args)
            flag_mismatch($sformatf("arg count %0d, want %0d (pos %0d)",
                o_arg_count, want.ent.args, want.ent.pos));
        if (o_status !== want.ent.status)
            flag_mismatch($sformatf("status %0d, want %0d (pos %0d)",
                o_status, want.ent.status, want.ent.pos));
        if (o_last_result !== want.last)
            flag_mismatch($sformatf("last flag %0d, want %0d (pos %0d)",
                o_last_result, want.last, want.ent.pos));
    endtask

    // ------------------------------------------------------------------------
    // stimulus builders
    // ------------------------------------------------------------------------
    function automatic logic [7:0] any_char();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_op();
        if ($urandom_range(0, 19) == 0) return any_char();
        return op_set[$urandom_range(0, 8)];
    endfunction

    task automatic stage(input logic [3:0] k, input logic [7:0] c);
        t_beat b;
        b.kind = k;
        b.ch = c;
        b.last = 1'b0;
        b.drain = 1'b0;
        expr_q.push_back(b);
    endtask

    task automatic stage_operand();
        case ($urandom_range(0, 2))
            0: stage(itp_pkg::KIND_STRING, any_char());
            1: stage(itp_pkg::KIND_NUMBER, any_char());
            default: stage(itp_pkg::KIND_VARIABLE, any_char());
        endcase
    endtask

    task automatic commit();
        expr_q[0].drain = hold_next;
        expr_q[expr_q.size()-1].last = 1'b1;
        hold_next = 1'b0;
        foreach (expr_q[i]) token_q.push_back(expr_q[i]);
        expr_q.delete();
    endtask

    // F function, ( ) parens, ',' comma, '"' string, digit number, lowercase
    // variable, '.' none, '?' spare kind, anything else an operator
    task automatic add_text(input string s);
        byte c;
        for (int i = 0; i < s.len(); i++) begin
            c = s[i];
            if (c == "F") stage(itp_pkg::KIND_FUNCTION, any_char());
            else if (c == "(") stage(itp_pkg::KIND_LEFT, any_char());
            else if (c == ")") stage(itp_pkg::KIND_RIGHT, any_char());
            else if (c == ",") stage(itp_pkg::KIND_COMMA, any_char());
            else if (c == "\"") stage(itp_pkg::KIND_STRING, any_char());
            else if (c == ".") stage(KIND_NONE, any_char());
            else if (c == "?") stage(KIND_SPARE, any_char());
            else if (c >= "0" && c <= "9") stage(itp_pkg::KIND_NUMBER, any_char());
            else if (c >= "a" && c <= "z") stage(itp_pkg::KIND_VARIABLE, any_char());
            else stage(itp_pkg::KIND_OPERATOR, c);
        end
        commit();
    endtask

    task automatic add_wellformed();
        int target;
        int open_cnt;
        int r;
        bit want_opnd;
        target = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 14);
        open_cnt = 0;
        want_opnd = 1'b1;
        forever begin
            r = $urandom_range(0, 9);
            if (want_opnd) begin
                if (expr_q.size() < target && open_cnt < 6 && r < 2) begin
                    stage(itp_pkg::KIND_LEFT, any_char());
                    open_cnt++;
                end else if (expr_q.size() < target && open_cnt < 6 && r < 4) begin
                    stage(itp_pkg::KIND_FUNCTION, any_char());
                    stage(itp_pkg::KIND_LEFT, any_char());
                    open_cnt++;
                end else begin
                    stage_operand();
                    want_opnd = 1'b0;
                end
            end else begin
                if (open_cnt > 0 && (r < 3 || expr_q.size() >= target)) begin
                    stage(itp_pkg::KIND_RIGHT, any_char());
                    open_cnt--;
                end else if (open_cnt > 0 && r < 5) begin
                    stage(itp_pkg::KIND_COMMA, any_char());
                    want_opnd = 1'b1;
                end else if (expr_q.size() >= target) begin
                    break;
                end else begin
                    stage(itp_pkg::KIND_OPERATOR, pick_op());
                    want_opnd = 1'b1;
                end
            end
        end
        commit();
    endtask

    task automatic add_noise();
        repeat ($urandom_range(1, 10)) stage(4'($urandom_range(0, 15)), any_char());
        commit();
    endtask

    task automatic add_long(input int n);
        for (int i = 0; i < n; i++) begin
            if (i % 2 == 0) stage_operand();
            else stage(itp_pkg::KIND_OPERATOR, pick_op());
        end
        commit();
    endtask

    task automatic add_deep(input int n);
        repeat (n) stage(itp_pkg::KIND_LEFT, any_char());
        stage(itp_pkg::KIND_NUMBER, any_char());
        commit();
    endtask

    task automatic build_stimulus();
        int base;
        int nexpr;
        int r;
        add_text("F(1=v%2,3^4^5)*6/7-8>9+a<b");
        add_text("F(G(1),2)");
        add_text(")");
        add_text("1)2");
        add_text("(1");
        add_text("?");
        base = token_q.size();
        nexpr = 0;
        while (token_q.size() < base + RANDOM_ITEMS) begin
            nexpr++;
            if (nexpr == 8 || $urandom_range(0, 24) == 0) hold_next = 1'b1;
            r = $urandom_range(0, 99);
            if (nexpr == 12) add_deep(TOKEN_LIMIT - 1);
            else if (nexpr == 16) add_long(TOKEN_LIMIT + 1);
            else if (nexpr == 20) add_long(TOKEN_LIMIT);
            else if (r < 74) add_wellformed();
            else if (r < 94) add_noise();
            else if (r < 97) add_long($urandom_range(TOKEN_LIMIT - 2, TOKEN_LIMIT + 6));
            else add_deep($urandom_range(30, TOKEN_LIMIT - 1));
        end
    endtask

    // ------------------------------------------------------------------------
    // driver, receiver and monitor
    // ------------------------------------------------------------------------
    function bit idling_off();
        return token_q.size() < CALM_TAIL || ((beats_in / 64) % 4) == 3;
    endfunction

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (push && !tok_beat) begin
            // beat still offered, hold it
        end else if (tok_gap > 0) begin
            push <= 1'b0;
            tok_gap--;
        end else if (token_q.size() == 0 || (token_q[0].drain && postfix_q.size() != 0)) begin
            push <= 1'b0;
        end else if (!idling_off() && $urandom_range(0, 7) == 0) begin
            push <= 1'b0;
            tok_gap = $urandom_range(0, 2);
        end else begin
            push <= 1'b1;
            i_token_kind <= token_q[0].kind;
            i_op_char <= token_q[0].ch;
            i_last_token <= token_q[0].last;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (res_gap > 0) begin
            pop <= 1'b0;
            res_gap--;
        end else if (!idling_off() && $urandom_range(0, 5) == 0) begin
            pop <= 1'b0;
            res_gap = $urandom_range(0, 2);
        end else begin
            pop <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        tok_beat = 1'b0;
        if (i_rst_n) begin
            if (push && !full) begin
                tok_beat = 1'b1;
                shunt_token(i_token_kind, i_op_char, i_last_token);
                void'(token_q.pop_front());
                beats_in++;
            end
            if (pop && !empty) check_result();
        end
    end

    // ------------------------------------------------------------------------
    // run control
    // ------------------------------------------------------------------------
    initial begin
        build_stimulus();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        while (token_q.size() != 0 || postfix_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (errors == 0) begin
            $display("infix_to_postfix_converter_tb: clean");
        end else begin
            $display("infix_to_postfix_converter_tb: errors");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("infix_to_postfix_converter_tb: errors");
        $finish;
    end

endmodule
